/* design/wbps_pkg.sv */
package wbps_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;

  // Fixed widths of the configuration registers and the ports.
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int CARE_W        = 16;
  localparam int LENGTH_REG_W  = 5;
  localparam int STATUS_W      = 2;
  localparam int MATCH_OFS_W   = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

  // Search status codes; the saturating match count uses the same codes.
  localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNIQUE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MULTI  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CARE_W-1:0]       CARE_MASK_RST      = 16'hFFFF;
  localparam logic [LENGTH_REG_W-1:0] PATTERN_LENGTH_RST = 5'd1;

endpackage

/* design/wildcard_byte_pattern_search_top.sv */
// A region's result is registered and shown the cycle after its last item is taken.
// One item per cycle unless the input is stalled; the window compare and counter
// updates are combinational from the accepted byte to the state and result registers.
// Input stalls only while a finished result is held and the output side stalls.
// Reset (rst, synchronous, active high) restores the configuration registers to their
// defaults, clears the per-region counters and empties the result register.
module wildcard_byte_pattern_search_top #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            data_byte,
  input  logic                                  region_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wbps_pkg::STATUS_W-1:0]         search_status,
  output logic [wbps_pkg::MATCH_OFS_W-1:0]      match_offset
);

  import wbps_pkg::*;

  // Width of an effective pattern length (1 to MAX_PATTERN_BYTES) and of a
  // window index (0 to MAX_PATTERN_BYTES - 1).
  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);
  localparam logic [OFFSET_BITS-1:0] SEEN_MAX = {OFFSET_BITS{1'b1}};

  // Configuration registers.
  logic [CFG_DATA_W-1:0]   pattern_low;
  logic [CFG_DATA_W-1:0]   pattern_high;
  logic [CARE_W-1:0]       care_mask;
  logic [LENGTH_REG_W-1:0] pattern_length;

  // Per-region state. The history holds the bytes received 1 to
  // MAX_PATTERN_BYTES - 1 items ago; the newest byte comes straight from the input.
  logic [7:0]             hist [MAX_PATTERN_BYTES-1];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [STATUS_W-1:0]    matches_found;
  logic [OFFSET_BITS-1:0] first_offset;

  // Combinational view of the state after the incoming byte.
  logic [7:0]             win_next [MAX_PATTERN_BYTES];
  logic [7:0]             pat_byte [MAX_PATTERN_BYTES];
  logic [LEN_W-1:0]       len_eff;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                   hit;
  logic [STATUS_W-1:0]    matches_next;
  logic [OFFSET_BITS-1:0] first_offset_next;
  logic                   in_accept;
  logic                   out_take;

  // The input side is held off only while a result waits and the output stalls.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;

  // A pattern length of zero counts as one, and anything beyond the window
  // depth counts as the full window.
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN_BYTES) begin
      len_eff = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  // The window as it stands once the new byte has been shifted in.
  assign win_next[0] = data_byte;
  for (genvar k = 1; k < MAX_PATTERN_BYTES; k++) begin : g_win
    assign win_next[k] = hist[k-1];
  end

  // Pattern byte g lines up with the byte received len_eff - 1 - g items ago.
  // Bytes past the length and wildcard bytes always agree.
  for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cmp
    logic [LEN_W-1:0] pos;
    assign pat_byte[g] = (g < 8) ? pattern_low[(g % 8) * 8 +: 8]
                                 : pattern_high[(g % 8) * 8 +: 8];
    assign pos        = len_eff - LEN_W'(g + 1);
    assign byte_ok[g] = (LEN_W'(g) >= len_eff) || !care_mask[g] ||
                        (win_next[pos[IDX_W-1:0]] == pat_byte[g]);
  end

  // The byte counter stops at its largest value; a match is only counted
  // once the whole pattern lies inside the region.
  assign bytes_seen_next = (bytes_seen == SEEN_MAX) ? bytes_seen
                                                    : bytes_seen + OFFSET_BITS'(1);
  assign start_offset    = bytes_seen_next - OFFSET_BITS'(len_eff);
  assign hit             = (bytes_seen_next >= OFFSET_BITS'(len_eff)) && (&byte_ok);

  always_comb begin
    matches_next      = matches_found;
    first_offset_next = first_offset;
    if (hit) begin
      if (matches_found == STATUS_NONE) begin
        matches_next      = STATUS_UNIQUE;
        first_offset_next = start_offset;
      end else begin
        matches_next = STATUS_MULTI;
      end
    end
  end

  // Configuration writes. A register keeps the low bits of the data word.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= CARE_MASK_RST;
      pattern_length <= PATTERN_LENGTH_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_CARE_MASK:      care_mask      <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LENGTH_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte history. Bytes from an earlier region never take part in a match,
  // because the counter gate only admits matches wholly inside this region.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
        hist[k] <= win_next[k];
      end
    end
  end

  // Region counters and the result register. The last item of a region loads
  // the result and starts the next region from zero in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      matches_found <= STATUS_NONE;
      first_offset  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        if (region_end) begin
          bytes_seen    <= '0;
          matches_found <= STATUS_NONE;
          first_offset  <= '0;
          out_valid     <= 1'b1;
          search_status <= matches_next;
          match_offset  <= (matches_next == STATUS_NONE) ? '0
                                                         : MATCH_OFS_W'(first_offset_next);
        end else begin
          bytes_seen    <= bytes_seen_next;
          matches_found <= matches_next;
          first_offset  <= first_offset_next;
        end
      end
    end
  end

endmodule

/* design/wbps_check.sv */
module wbps_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              region_end,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [wbps_pkg::STATUS_W-1:0]     search_status,
  input logic [wbps_pkg::MATCH_OFS_W-1:0]  match_offset
);

  import wbps_pkg::*;

  // A held result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(search_status) && $stable(match_offset))
    else $error("held result changed");

  // A region without a match reports offset zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && search_status == STATUS_NONE |-> match_offset == '0)
    else $error("nonzero offset with no match");

  // A new result only follows an accepted last item of a region.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && region_end))
    else $error("result without region end");

  // An item in the middle of a region never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !region_end && !out_valid |=> !out_valid)
    else $error("result from a non-final item");

  // Input is held off only behind a waiting result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind wildcard_byte_pattern_search_top wbps_check u_wbps_check (.*);

/* bench/tb_wildcard_byte_pattern_search_top.sv */
module tb_wildcard_byte_pattern_search_top;
  import wbps_pkg::*;

  // The window depth follows the default top-level parameter; the offset counter
  // is 32 bits wide, so it saturates at all ones. That point lies far beyond any
  // run of practical length, so counter saturation is modeled but not reached.
  localparam int WIN = MAX_PATTERN_BYTES_DEF;
  localparam int ITEM_TARGET = 1450;
  // From this item count on, no random gaps or stalls: regions run at full rate.
  localparam int CALM_FROM = 1250;
  localparam int MAX_REGION = 150;
  // Longest quiet stretch a correct run can show is a sender gap and a result
  // stall back to back plus a few settling cycles; this leaves ample margin.
  localparam int WATCHDOG_LIMIT = 400;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [MATCH_OFS_W-1:0] offset;
  } report_t;

  // One row of the directed part: either a register write or one item.
  // Rows with typed set carry a result that is obvious by inspection.
  typedef struct packed {
    logic                   is_write;
    logic [CFG_INDEX_W-1:0] reg_sel;
    logic [CFG_DATA_W-1:0]  value;
    logic [7:0]             b;
    logic                   last;
    logic                   typed;
    report_t                want;
  } step_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              data_byte = '0;
  logic                    region_end = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     search_status;
  logic [MATCH_OFS_W-1:0]  match_offset;

  wildcard_byte_pattern_search_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .region_end   (region_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .search_status(search_status),
    .match_offset (match_offset)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shadow copy of the search engine: configuration registers and the
  // per-region scan state.
  logic [63:0]           pat_lo_m;
  logic [63:0]           pat_hi_m;
  logic [CARE_W-1:0]     care_m;
  logic [LENGTH_REG_W-1:0] len_m;
  logic [7:0]            window_m [WIN];
  logic [31:0]           seen_m;
  logic [STATUS_W-1:0]   hits_m;
  logic [31:0]           first_m;

  report_t     awaited_reports [$];
  step_row_t   directed_rows [$];
  logic [7:0]  region_bytes [MAX_REGION];
  int unsigned items_sent = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  bit          calm_tail = 1'b0;

  function automatic logic [7:0] pattern_byte(int unsigned i);
    return (i < 8) ? pat_lo_m[8*i +: 8] : pat_hi_m[8*(i-8) +: 8];
  endfunction

  // A length of zero acts as one, and lengths past the window depth are clipped.
  function automatic int unsigned live_length();
    int unsigned n;
    n = len_m;
    if (n == 0) n = 1;
    if (n > WIN) n = WIN;
    return n;
  endfunction

  function automatic void clear_region();
    for (int k = 0; k < WIN; k++) window_m[k] = 8'h00;
    seen_m  = '0;
    hits_m  = STATUS_NONE;
    first_m = '0;
  endfunction

  // Shift one byte into the window, count a match that ends here, and on the
  // last byte of a region hand back the report and start a fresh region.
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output report_t rep);
    int unsigned n;
    bit hit;
    n = live_length();
    for (int k = WIN - 1; k > 0; k--) window_m[k] = window_m[k-1];
    window_m[0] = b;
    if (seen_m != '1) seen_m = seen_m + 1;
    hit = (seen_m >= n);
    for (int i = 0; i < n; i++)
      if (care_m[i] && window_m[n-1-i] != pattern_byte(i)) hit = 1'b0;
    if (hit) begin
      if (hits_m == STATUS_NONE) first_m = seen_m - n;
      if (hits_m != STATUS_MULTI) hits_m = hits_m + 1'b1;
    end
    rep.status = hits_m;
    rep.offset = (hits_m == STATUS_NONE) ? '0 : first_m;
    if (last) clear_region();
    return last;
  endfunction

  function automatic step_row_t write_row(logic [CFG_INDEX_W-1:0] sel, logic [63:0] value);
    step_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_sel = sel;
    row.value = value;
    return row;
  endfunction

  function automatic step_row_t byte_row(logic [7:0] b, logic last, logic typed,
                                         logic [STATUS_W-1:0] st, logic [31:0] ofs);
    step_row_t row;
    row = '0;
    row.b = b;
    row.last = last;
    row.typed = typed;
    row.want.status = st;
    row.want.offset = ofs;
    return row;
  endfunction

  // Append one row to the end of the directed table.
  function automatic void add_row(step_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic logic [7:0] pick_byte(bit tiny);
    if (tiny) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Registers change only with the input side idle and every report delivered.
  // Every region ends in a report, so an empty queue means the block is between
  // regions.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The shadow registers follow the write at the edge that performs it, with
  // the same masking to register width as the block.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [63:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    case (sel)
      REG_PATTERN_LOW:    pat_lo_m = value;
      REG_PATTERN_HIGH:   pat_hi_m = value;
      REG_CARE_MASK:      care_m = value[CARE_W-1:0];
      REG_PATTERN_LENGTH: len_m = value[LENGTH_REG_W-1:0];
      default: ;
    endcase
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Present one item and hold it until the block takes it. Stall is sampled on
  // the falling edge, where it already holds the value the next rising edge sees.
  task automatic accept_byte(input logic [7:0] b, input logic last, input logic typed,
                             input report_t typed_rep);
    bit taken;
    report_t rep;
    in_valid <= 1'b1;
    data_byte <= b;
    region_end <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    items_sent++;
    if (items_sent >= CALM_FROM) calm_tail = 1'b1;
    if (scan_byte(b, last, rep))
      awaited_reports = {awaited_reports, (typed ? typed_rep : rep)};
  endtask

  task automatic maybe_gap(input bit gappy);
    if (gappy && !calm_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Build one region of r bytes. Most regions carry one to three copies of the
  // configured pattern with random bytes in the wildcard positions, sometimes
  // overlapping and sometimes with one byte flipped so the copy may nearly match.
  task automatic stream_region(input int unsigned r, input bit gappy, input bit tiny);
    int unsigned n;
    int unsigned at;
    int unsigned prev_at;
    for (int j = 0; j < r; j++) region_bytes[j] = pick_byte(tiny);
    n = live_length();
    prev_at = 0;
    if (r >= n && $urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(1, 3)) begin
        at = $urandom_range(0, r - n);
        if ($urandom_range(0, 2) == 0) begin
          at = prev_at + $urandom_range(1, n);
          if (at > r - n) at = r - n;
        end
        for (int i = 0; i < n; i++)
          if (care_m[i]) region_bytes[at+i] = pattern_byte(i);
        if ($urandom_range(0, 4) == 0)
          region_bytes[at + $urandom_range(0, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
        prev_at = at;
      end
    end
    for (int j = 0; j < r; j++) begin
      maybe_gap(gappy);
      accept_byte(region_bytes[j], j == r - 1, 1'b0, '0);
    end
  endtask

  // Result side: stall in bursts separated by open stretches, and never once the
  // tail of the run has begun.
  initial begin : result_sink
    int unsigned burst;
    while (rst) @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 2) == 0 && !calm_tail) ? $urandom_range(1, 18) : 0;
      if (burst != 0) begin
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Each report the block hands over is checked against the oldest one awaited.
  // A report is taken at the rising edge that follows this falling edge.
  always @(negedge clk) begin
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected report: search_status=%0d match_offset=%0d",
               search_status, match_offset);
        fault_count++;
      end else begin
        want = awaited_reports.pop_front();
        if (search_status !== want.status) begin
          $error("search_status: expected %0d, actual %0d", want.status, search_status);
          fault_count++;
        end
        if (match_offset !== want.offset) begin
          $error("match_offset: expected %0d, actual %0d", want.offset, match_offset);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: ends the run once too many cycles pass without either channel
  // moving an item.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("wildcard_byte_pattern_search_top test failed");
    $finish;
  end

  initial begin : stimulus
    bit gappy;
    bit tiny;
    int unsigned r;
    int unsigned phase;
    logic [63:0] v;

    pat_lo_m = '0;
    pat_hi_m = '0;
    care_m = CARE_MASK_RST;
    len_m = PATTERN_LENGTH_RST;
    clear_region();

    // Directed rows. With the reset configuration the pattern is the single byte
    // zero with its care bit set, so the first regions can be judged by eye.
    add_row(byte_row(8'h00, 1'b1, 1'b1, STATUS_UNIQUE, 32'd0));
    add_row(byte_row(8'hFF, 1'b0, 1'b0, STATUS_NONE, 32'd0));
    add_row(byte_row(8'h00, 1'b0, 1'b0, STATUS_NONE, 32'd0));
    add_row(byte_row(8'h00, 1'b1, 1'b1, STATUS_MULTI, 32'd1));
    add_row(byte_row(8'hFF, 1'b1, 1'b1, STATUS_NONE, 32'd0));
    // A length of zero behaves as a length of one.
    add_row(write_row(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(write_row(REG_PATTERN_LENGTH, 64'd0));
    add_row(byte_row(8'hFF, 1'b1, 1'b1, STATUS_UNIQUE, 32'd0));
    // All wildcards over two bytes: a one-byte region is too short to hold a
    // match, while three bytes hold two overlapping ones.
    add_row(write_row(REG_CARE_MASK, 64'd0));
    add_row(write_row(REG_PATTERN_LENGTH, 64'd2));
    add_row(byte_row(8'h12, 1'b1, 1'b1, STATUS_NONE, 32'd0));
    add_row(byte_row(8'hAB, 1'b0, 1'b0, STATUS_NONE, 32'd0));
    add_row(byte_row(8'h00, 1'b0, 1'b0, STATUS_NONE, 32'd0));
    add_row(byte_row(8'h55, 1'b1, 1'b1, STATUS_MULTI, 32'd0));
    // An oversized length is clipped to the full window; only the first and the
    // last pattern byte are cared for, so the full-length region matches once.
    add_row(write_row(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(write_row(REG_CARE_MASK, 64'h8001));
    add_row(write_row(REG_PATTERN_LENGTH, 64'h1F));
    add_row(byte_row(8'hFF, 1'b0, 1'b0, STATUS_NONE, 32'd0));
    for (int k = 0; k < 14; k++)
      add_row(byte_row(8'(k * 8'h13), 1'b0, 1'b0, STATUS_NONE, 32'd0));
    add_row(byte_row(8'hFF, 1'b1, 1'b1, STATUS_UNIQUE, 32'd0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        settle_idle();
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        maybe_gap(1'b1);
        accept_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                    directed_rows[i].want);
      end
    end

    // Random phases: each one drains the block, may rewrite any of the registers
    // (junk above the care mask and length widths) and streams a few regions.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      tiny = ($urandom_range(0, 2) == 0);
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < 8; i++) v[8*i +: 8] = pick_byte(tiny);
        write_reg(REG_PATTERN_LOW, v);
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < 8; i++) v[8*i +: 8] = pick_byte(tiny);
        write_reg(REG_PATTERN_HIGH, v);
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
          0: v[CARE_W-1:0] = '0;
          1: v[CARE_W-1:0] = '1;
          default: ;
        endcase
        write_reg(REG_CARE_MASK, v);
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
          0: v[LENGTH_REG_W-1:0] = '0;
          1: v[LENGTH_REG_W-1:0] = LENGTH_REG_W'($urandom_range(WIN + 1, 31));
          2: v[LENGTH_REG_W-1:0] = LENGTH_REG_W'(WIN);
          default: v[LENGTH_REG_W-1:0] = LENGTH_REG_W'($urandom_range(1, WIN));
        endcase
        write_reg(REG_PATTERN_LENGTH, v);
      end
      gappy = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(2, 8)) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(41, MAX_REGION)
                                         : $urandom_range(1, 40);
        // Stop starting new regions once the item budget is spent.
        if (items_sent < ITEM_TARGET) stream_region(r, gappy, tiny);
      end
      phase++;
    end

    // Drain: wait for every awaited report, then a few cycles more so that a
    // stray extra report would still be caught.
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("wildcard_byte_pattern_search_top test passed");
    else
      $display("wildcard_byte_pattern_search_top test failed");
    $finish;
  end

endmodule
